// ----- hdl/miller_rabin_trial_core_defines.svh -----
// assertion macros shared by the miller-rabin trial checker
// depends on: a clk and an active-low rst_n in the scope of each use
`ifndef MILLER_RABIN_TRIAL_CORE_DEFINES_SVH
`define MILLER_RABIN_TRIAL_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define MRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mrt_pkg.sv -----
// shared types and constants for the miller-rabin trial core
// depends on: nothing
package mrt_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int FIELD_W   = 64;
    localparam int CNT_W     = $clog2(NUM_WIDTH);

    typedef logic [FIELD_W-1:0]   field_t;
    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam num_t NUM_ONE   = num_t'(1);
    localparam num_t NUM_TWO   = num_t'(2);
    localparam num_t NUM_THREE = num_t'(3);

    // request to the modular multiplier
    typedef struct packed {
        logic start;
        num_t x;
        num_t y;
    } mul_req_t;

    // status back from the modular multiplier
    typedef struct packed {
        logic done;
        num_t product;
    } mul_rsp_t;

endpackage

// ----- hdl/mrt_ifs.sv -----
// valid/ready channels of the miller-rabin trial core
// depends on: mrt_pkg
interface mrt_req_if;
    import mrt_pkg::*;

    logic   valid;
    logic   ready;
    field_t candidate;
    field_t random_value;

    modport source (output valid, output candidate, output random_value, input ready);
    modport sink   (input valid, input candidate, input random_value, output ready);
endinterface

interface mrt_rsp_if;
    logic valid;
    logic ready;
    logic probably_prime;
    logic trivially_decided;

    modport source (output valid, output probably_prime, output trivially_decided, input ready);
    modport sink   (input valid, input probably_prime, input trivially_decided, output ready);
endinterface

// ----- hdl/mrt_modmul.sv -----
// bit-serial modular multiplier, add-and-double, one multiplier bit per cycle
// depends on: mrt_pkg
module mrt_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  mrt_pkg::mul_req_t req,
    input  mrt_pkg::num_t     modulus,
    output mrt_pkg::mul_rsp_t rsp
);
    import mrt_pkg::*;

    logic busy_reg, busy_next;
    num_t acc_reg, acc_next;
    num_t addend_reg, addend_next;
    num_t mult_reg, mult_next;

    // (x + y) mod m for x, y < m, with a carry bit so m >= 2^(w-1) is exact
    function automatic num_t add_mod(input num_t x, input num_t y, input num_t m);
        logic [NUM_WIDTH:0] sum;
        logic [NUM_WIDTH:0] diff;
        begin
            sum  = {1'b0, x} + {1'b0, y};
            diff = sum - {1'b0, m};
            if (sum >= {1'b0, m})
            begin
                return diff[NUM_WIDTH-1:0];
            end
            return sum[NUM_WIDTH-1:0];
        end
    endfunction

    assign rsp.done    = busy_reg && (mult_reg == '0);
    assign rsp.product = acc_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mult_next   = mult_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            acc_next    = '0;
            addend_next = req.x;
            mult_next   = req.y;
        end
        else if (busy_reg)
        begin
            if (mult_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (mult_reg[0])
                begin
                    acc_next = add_mod(acc_reg, addend_reg, modulus);
                end
                addend_next = add_mod(addend_reg, addend_reg, modulus);
                mult_next   = mult_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mult_reg   <= mult_next;
    end

endmodule

// ----- hdl/miller_rabin_trial_core.sv -----
// one miller-rabin witness round on a 64-bit candidate
// depends on: mrt_pkg, mrt_ifs (mrt_req_if, mrt_rsp_if), mrt_modmul
//
// usage:
//   req carries candidate and random_value; rsp returns probably_prime and
//   trivially_decided, one response per request, in order.
//   req.ready is high only while the core is idle; one request is in work
//   at a time.
// sequence:
//   candidates 0..3 and even ones: straight to ST_FIN, which loads the output register once free.
//   odd candidates of 5 and up: restoring division for the witness (the
//   exponent split runs alongside), then square-and-multiply over the bits
//   of d and up to s-1 squarings. every modular multiply goes through the
//   one bit-serial multiplier, which holds the round until it is done.
// reset: asynchronous, active low; the core comes up idle with rsp.valid low.
// stall: the verdict sits in the output register until rsp.ready; a new
//   request is taken meanwhile, and its verdict waits for the register.
module miller_rabin_trial_core (
    input  logic  clk,
    input  logic  rst_n,
    mrt_req_if.sink   req,
    mrt_rsp_if.source rsp
);
    import mrt_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_DIV     = 8'b0000_0010,
        ST_POW     = 8'b0000_0100,
        ST_POW_MUL = 8'b0000_1000,
        ST_POW_SQ  = 8'b0001_0000,
        ST_CHK     = 8'b0010_0000,
        ST_SQR     = 8'b0100_0000,
        ST_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // operands kept for the whole round
    num_t nm1_reg, nm1_next;       // candidate - 1
    num_t nm3_reg, nm3_next;       // candidate - 3, divisor for the witness
    num_t n_reg, n_next;           // modulus

    // witness reduction
    num_t r_reg, r_next;           // random bits, msb first
    num_t rem_reg, rem_next;
    cnt_t cnt_reg, cnt_next;

    // exponent split and squaring count
    num_t d_reg, d_next;
    cnt_t s_reg, s_next;

    // exponentiation
    num_t acc_reg, acc_next;
    num_t sq_reg, sq_next;

    // verdict and output register
    logic prime_reg, prime_next;
    logic trivial_reg, trivial_next;
    logic out_valid_reg, out_valid_next;
    logic out_prime_reg, out_prime_next;
    logic out_trivial_reg, out_trivial_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    num_t               n_in;
    num_t               r_in;
    logic [NUM_WIDTH:0] div_tmp;
    logic [NUM_WIDTH:0] div_sub;

    mrt_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .modulus (n_reg),
        .rsp     (mul_rsp)
    );

    // only the low NUM_WIDTH bits of each field count
    assign n_in = req.candidate[NUM_WIDTH-1:0];
    assign r_in = req.random_value[NUM_WIDTH-1:0];

    // one restoring division step: shift in the next random bit
    assign div_tmp = {rem_reg, r_reg[NUM_WIDTH-1]};
    assign div_sub = div_tmp - {1'b0, nm3_reg};

    assign req.ready             = (state_reg == ST_IDLE);
    assign rsp.valid             = out_valid_reg;
    assign rsp.probably_prime    = out_prime_reg;
    assign rsp.trivially_decided = out_trivial_reg;

    always_comb
    begin
        state_next       = state_reg;
        nm1_next         = nm1_reg;
        nm3_next         = nm3_reg;
        n_next           = n_reg;
        r_next           = r_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        d_next           = d_reg;
        s_next           = s_reg;
        acc_next         = acc_reg;
        sq_next          = sq_reg;
        prime_next       = prime_reg;
        trivial_next     = trivial_reg;
        out_valid_next   = out_valid_reg;
        out_prime_next   = out_prime_reg;
        out_trivial_next = out_trivial_reg;
        mul_req.start    = 1'b0;
        mul_req.x        = acc_reg;
        mul_req.y        = sq_reg;

        // output register drains independently of the round in work
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    n_next       = n_in;
                    nm1_next     = n_in - NUM_ONE;
                    nm3_next     = n_in - NUM_THREE;
                    r_next       = r_in;
                    rem_next     = '0;
                    cnt_next     = '0;
                    d_next       = n_in - NUM_ONE;
                    s_next       = '0;
                    trivial_next = 1'b1;
                    if (n_in <= NUM_ONE)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FIN;
                    end
                    else if (n_in <= NUM_THREE)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (!n_in[0])
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        trivial_next = 1'b0;
                        state_next   = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // random_value mod (n - 3), one bit a cycle
                if (div_tmp >= {1'b0, nm3_reg})
                begin
                    rem_next = div_sub[NUM_WIDTH-1:0];
                end
                else
                begin
                    rem_next = div_tmp[NUM_WIDTH-1:0];
                end
                r_next   = r_reg << 1;
                // strip trailing zeros of n - 1 alongside
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + cnt_t'(1);
                end
                // the count stays on its last value to mark the first pow pass
                if (cnt_reg == cnt_t'(NUM_WIDTH - 1))
                begin
                    state_next = ST_POW;
                end
                else
                begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end

            ST_POW:
            begin
                // witness = 2 + remainder, taken on the first pass
                if (cnt_reg == cnt_t'(NUM_WIDTH - 1))
                begin
                    sq_next  = rem_reg + NUM_TWO;
                    acc_next = NUM_ONE;
                    cnt_next = '0;
                end
                else if (d_reg == '0)
                begin
                    state_next = ST_CHK;
                end
                else if (d_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.x     = acc_reg;
                    mul_req.y     = sq_reg;
                    state_next    = ST_POW_MUL;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.x     = sq_reg;
                    mul_req.y     = sq_reg;
                    state_next    = ST_POW_SQ;
                end
            end

            ST_POW_MUL:
            begin
                if (mul_rsp.done)
                begin
                    acc_next      = mul_rsp.product;
                    mul_req.start = 1'b1;
                    mul_req.x     = sq_reg;
                    mul_req.y     = sq_reg;
                    state_next    = ST_POW_SQ;
                end
            end

            ST_POW_SQ:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_rsp.product;
                    d_next     = d_reg >> 1;
                    state_next = ST_POW;
                end
            end

            ST_CHK:
            begin
                if ((acc_reg == NUM_ONE) || (acc_reg == nm1_reg))
                begin
                    prime_next = 1'b1;
                    state_next = ST_FIN;
                end
                else if (s_reg <= cnt_t'(1))
                begin
                    prime_next = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    // s now counts the squarings still allowed
                    s_next        = s_reg - cnt_t'(1);
                    mul_req.start = 1'b1;
                    mul_req.x     = acc_reg;
                    mul_req.y     = acc_reg;
                    state_next    = ST_SQR;
                end
            end

            ST_SQR:
            begin
                if (mul_rsp.done)
                begin
                    acc_next = mul_rsp.product;
                    if (mul_rsp.product == nm1_reg)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (s_reg == cnt_t'(1))
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        s_next        = s_reg - cnt_t'(1);
                        mul_req.start = 1'b1;
                        mul_req.x     = mul_rsp.product;
                        mul_req.y     = mul_rsp.product;
                    end
                end
            end

            ST_FIN:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_prime_next   = prime_reg;
                    out_trivial_next = trivial_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm1_reg         <= nm1_next;
        nm3_reg         <= nm3_next;
        n_reg           <= n_next;
        r_reg           <= r_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        d_reg           <= d_next;
        s_reg           <= s_next;
        acc_reg         <= acc_next;
        sq_reg          <= sq_next;
        prime_reg       <= prime_next;
        trivial_reg     <= trivial_next;
        out_prime_reg   <= out_prime_next;
        out_trivial_reg <= out_trivial_next;
    end

endmodule

// ----- hdl/mrt_checker.sv -----
// port-level checks for the miller-rabin trial core, bound to the top level
// depends on: miller_rabin_trial_core_defines.svh, miller_rabin_trial_core
`include "miller_rabin_trial_core_defines.svh"

module mrt_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_probably_prime,
    input logic rsp_trivially_decided
);

    // a stalled response stays up
    `MRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // a stalled verdict does not change
    `MRT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
        $stable(rsp_probably_prime) && $stable(rsp_trivially_decided),
        "verdict changed while stalled")

    // one request in work at a time
    `MRT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
        "request taken while a round is in work")

    // a new verdict only appears at the end of a round
    `MRT_ASSERT_NOW(a_rsp_from_round, $rose(rsp_valid), !$past(req_ready),
        "response without a round in work")

endmodule

bind miller_rabin_trial_core mrt_checker u_mrt_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_probably_prime    (rsp.probably_prime),
    .rsp_trivially_decided (rsp.trivially_decided)
);

// ----- test/tb_miller_rabin_trial_core.sv -----
// testbench for miller_rabin_trial_core: directed table, a back-pressure phase, then random
// requests, verdicts checked in order (table or 128-bit-product model of one witness round)
// depends on: mrt_pkg, mrt_ifs (mrt_req_if, mrt_rsp_if), miller_rabin_trial_core
module tb_miller_rabin_trial_core;
    import mrt_pkg::*;

    localparam int     HALF_PERIOD     = 4;
    localparam int     RESET_CYCLES    = 12;
    // receiver hold-off, long enough for the core to fill and stall its input
    localparam int     HOLD_OFF_CYCLES = 400;
    // above the worst odd candidate's round, plus stalls on both sides
    localparam int     STALL_LIMIT     = 100000;
    // a trivial verdict needs only ST_FIN after its request, so this catches any stray response
    localparam int     TAIL_CYCLES     = 16;
    localparam int     PRESSURE_BURST  = 8;
    localparam int     RANDOM_REQUESTS = 72;
    // the last random requests run with no idling on either side
    localparam int     CALM_REQUESTS   = 15;
    localparam field_t ALL_ONES        = '1;

    // one directed request; known rows carry their verdict, others go to the model
    typedef struct packed {
        field_t candidate;
        field_t random_value;
        logic   known;
        logic   prime;
        logic   trivial;
    } stim_row_t;

    // one verdict still owed by the core
    typedef struct packed {
        field_t candidate;
        field_t random_value;
        logic   prime;
        logic   trivial;
    } verdict_t;

    localparam int DIRECTED_ROWS = 22;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // small candidates, decided without a witness
        '{64'd0, 64'd0, 1'b1, 1'b0, 1'b1},
        '{64'd1, ALL_ONES, 1'b1, 1'b0, 1'b1},
        '{64'd2, 64'd0, 1'b1, 1'b1, 1'b1},
        '{64'd3, ALL_ONES, 1'b1, 1'b1, 1'b1},
        // even candidates, composite without a witness
        '{64'd4, 64'd7, 1'b1, 1'b0, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFE, ALL_ONES, 1'b1, 1'b0, 1'b1},
        '{64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b1},
        // smallest odd candidate: the witness range is just 2 values
        '{64'd5, ALL_ONES, 1'b0, 1'b0, 1'b0},
        '{64'd5, 64'd0, 1'b0, 1'b0, 1'b0},
        '{64'd7, 64'd0, 1'b0, 1'b0, 1'b0},
        // s = 3, so the squaring loop runs
        '{64'd9, 64'd5, 1'b0, 1'b0, 1'b0},
        // strong pseudoprime to base 2 (witness 2), then witness 3
        '{64'd2047, 64'd0, 1'b0, 1'b0, 1'b0},
        '{64'd2047, 64'd1, 1'b0, 1'b0, 1'b0},
        '{64'd561, 64'd0, 1'b0, 1'b0, 1'b0},
        '{64'd3215031751, 64'd0, 1'b0, 1'b0, 1'b0},
        // largest odd candidate, composite
        '{ALL_ONES, ALL_ONES, 1'b0, 1'b0, 1'b0},
        // largest 64-bit prime, with witnesses 2 and 63
        '{64'hFFFF_FFFF_FFFF_FFC5, 64'd0, 1'b0, 1'b0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFC5, ALL_ONES, 1'b0, 1'b0, 1'b0},
        '{64'h7FFF_FFFF_FFFF_FFE7, 64'd123, 1'b0, 1'b0, 1'b0},
        // moduli of 2^63 and above stress the 65-bit doubling, then 2^61 - 1
        '{64'h8000_0000_0000_0001, ALL_ONES, 1'b0, 1'b0, 1'b0},
        '{64'hC000_0000_0000_0003, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0},
        '{64'h1FFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 1'b0, 1'b0}
    };

    // primes and strong pseudoprimes, so that passing verdicts come up often
    field_t notable_candidates [10] = '{
        64'hFFFF_FFFF_FFFF_FFC5,
        64'h7FFF_FFFF_FFFF_FFE7,
        64'h1FFF_FFFF_FFFF_FFFF,
        64'd1000000007,
        64'd998244353,
        64'd4294967291,
        64'd2047,
        64'd561,
        64'd3215031751,
        64'd3825123056546413051
    };

    logic clk;
    logic rst_n;

    mrt_req_if req_ch ();
    mrt_rsp_if rsp_ch ();

    miller_rabin_trial_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    verdict_t pending_verdicts [$];
    int       mismatches;
    int       quiet_cycles;
    // control from the stimulus process to the response side
    logic     rx_idling;
    int       hold_off_count;
    // sender idling, used only by the stimulus process
    logic     tx_idling;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // model of one witness round; products are formed at full 128 bits
    // ------------------------------------------------------------------
    function automatic num_t mod_mul(num_t x, num_t y, num_t m);
        logic [2*NUM_WIDTH-1:0] product;
        product = {{NUM_WIDTH{1'b0}}, x} * {{NUM_WIDTH{1'b0}}, y};
        return num_t'(product % {{NUM_WIDTH{1'b0}}, m});
    endfunction

    function automatic num_t mod_pow(num_t base_val, num_t expo, num_t m);
        num_t acc;
        num_t sq;
        acc = NUM_ONE;
        sq  = base_val % m;
        while (expo != '0)
        begin
            if (expo[0])
                acc = mod_mul(acc, sq, m);
            sq   = mod_mul(sq, sq, m);
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // odd n of 5 and up: does it survive the witness picked by r
    function automatic logic passes_round(num_t n, num_t r);
        num_t nm1;
        num_t odd_part;
        num_t witness;
        num_t x;
        int   twos;
        nm1      = n - NUM_ONE;
        odd_part = nm1;
        twos     = 0;
        while (!odd_part[0])
        begin
            odd_part = odd_part >> 1;
            twos++;
        end
        witness = NUM_TWO + r % (n - NUM_THREE);
        x       = mod_pow(witness, odd_part, n);
        if (x == NUM_ONE || x == nm1)
            return 1'b1;
        for (int j = 1; j < twos; j++)
        begin
            x = mod_mul(x, x, n);
            if (x == nm1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic verdict_t predict_verdict(field_t cand, field_t rv);
        verdict_t v;
        num_t     n;
        num_t     r;
        n = cand[NUM_WIDTH-1:0];
        r = rv[NUM_WIDTH-1:0];
        v.candidate    = cand;
        v.random_value = rv;
        v.trivial      = 1'b1;
        if (n <= NUM_ONE)
            v.prime = 1'b0;
        else if (n <= NUM_THREE)
            v.prime = 1'b1;
        else if (!n[0])
            v.prime = 1'b0;
        else
        begin
            v.trivial = 1'b0;
            v.prime   = passes_round(n, r);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // random request content
    // ------------------------------------------------------------------
    // mostly odd candidates of small width (the core's time grows with
    // width), some notable ones, a few wide ones and some noise
    function automatic field_t random_candidate();
        int     pick;
        int     w;
        field_t v;
        pick = $urandom_range(0, 99);
        v    = {$urandom, $urandom};
        if (pick < 15)
        begin
            case ($urandom_range(0, 2))
                0:       v = field_t'($urandom_range(0, 3));
                1:       v = v & ~field_t'(1);
                default: v = field_t'($urandom_range(2, 500)) << 1;
            endcase
        end
        else if (pick < 25)
            v = notable_candidates[$urandom_range(0, 9)];
        else
        begin
            w = (pick < 85) ? $urandom_range(3, 20) : $urandom_range(21, FIELD_W);
            if (w < FIELD_W)
                v = v & ((field_t'(1) << w) - field_t'(1));
            v[w-1] = 1'b1;
            v[0]   = 1'b1;
            if (v < field_t'(5))
                v = field_t'(5);
        end
        return v;
    endfunction

    function automatic field_t random_draw();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ALL_ONES;
        if (pick == 2)
            return field_t'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // offer one request until the core takes it, then record its verdict;
    // valid stays high into the next request unless a gap is drawn
    task automatic offer_request(input field_t cand, input field_t rv, input logic known,
                                 input logic exp_prime, input logic exp_trivial);
        verdict_t v;
        int       gap;
        if (known)
            v = '{cand, rv, exp_prime, exp_trivial};
        else
            v = predict_verdict(cand, rv);
        req_ch.valid        <= 1'b1;
        req_ch.candidate    <= cand;
        req_ch.random_value <= rv;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_verdicts.push_back(v);
        if (tx_idling && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender goes quiet until every owed verdict has come back
    task automatic drain_verdicts();
        req_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        field_t cand;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.candidate    = '0;
        req_ch.random_value = '0;
        rx_idling           = 1'b1;
        tx_idling           = 1'b1;
        hold_off_count      = 0;
        mismatches          = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling <= ($urandom_range(0, 3) != 0);
            offer_request(directed_rows[i].candidate, directed_rows[i].random_value,
                          directed_rows[i].known, directed_rows[i].prime,
                          directed_rows[i].trivial);
        end
        drain_verdicts();

        // back-pressure: the receiver holds off while requests keep coming, so
        // the output register fills, a second verdict waits and ready drops
        tx_idling = 1'b0;
        hold_off_count <= hold_off_count + 1;
        for (int k = 0; k < PRESSURE_BURST; k++)
        begin
            if (k < 2)
                cand = field_t'($urandom_range(0, 3));
            else if (k == PRESSURE_BURST - 1)
                cand = (field_t'($urandom_range(2, 127)) << 1) | field_t'(1);
            else
                cand = {$urandom, $urandom} & ~field_t'(1);
            offer_request(cand, random_draw(), 1'b0, 1'b0, 1'b0);
        end
        drain_verdicts();

        // random requests; idling per request, none at the very end
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k >= RANDOM_REQUESTS - CALM_REQUESTS)
            begin
                tx_idling = 1'b0;
                rx_idling <= 1'b0;
            end
            else
            begin
                tx_idling = ($urandom_range(0, 3) != 0);
                rx_idling <= ($urandom_range(0, 3) != 0);
            end
            offer_request(random_candidate(), random_draw(), 1'b0, 1'b0, 1'b0);
        end
        drain_verdicts();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // response side: check each verdict, drive ready with stall bursts and
    // the long hold-off counted here
    // ------------------------------------------------------------------
    task automatic check_verdict(input logic got_prime, input logic got_trivial);
        verdict_t want;
        if (pending_verdicts.size() == 0)
        begin
            $display("%0t: response with no request owed: probably_prime %b trivially_decided %b",
                     $time, got_prime, got_trivial);
            mismatches++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got_prime !== want.prime)
        begin
            $display("%0t: candidate %h random %h: probably_prime expected %b actual %b",
                     $time, want.candidate, want.random_value, want.prime, got_prime);
            mismatches++;
        end
        if (got_trivial !== want.trivial)
        begin
            $display("%0t: candidate %h random %h: trivially_decided expected %b actual %b",
                     $time, want.candidate, want.random_value, want.trivial, got_trivial);
            mismatches++;
        end
    endtask

    initial
    begin : response_side
        int stall_left;
        int holds_taken;

        stall_left   = 0;
        holds_taken  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_verdict(rsp_ch.probably_prime, rsp_ch.trivially_decided);
            if (hold_off_count > holds_taken)
            begin
                holds_taken++;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                // start a stall burst with this cycle; stall_left holds the rest of it
                stall_left = $urandom_range(0, 7);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog: too long with neither a request nor a response taken
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mrt_pkg.sv
hdl/mrt_ifs.sv
hdl/mrt_modmul.sv
hdl/miller_rabin_trial_core.sv
hdl/mrt_checker.sv
test/tb_miller_rabin_trial_core.sv
